/* rtl/sba_pkg.sv */
// Shared types, constants and command/status structs of the surround bed accumulator.
package sba_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 15;
  localparam int CC_W         = 4;
  localparam int FRAME_W      = 10;
  localparam int ACC_W        = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 15;

  // Store geometry.
  localparam int DEFAULT_FRAME_DEPTH = 1024;
  localparam int MAX_CHANNELS        = 8;
  localparam int SLOTS               = 5;
  localparam int SLOT_W              = 3;

  // Register reset values.
  localparam logic [CC_W-1:0]   CC_RESET   = 4'd2;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

  // Fixed-point constants: -3 dB in Q0.15, and the rounding shifts.
  localparam logic [GAIN_W-1:0] MINUS3DB_Q15 = 15'd23170;
  localparam int GAIN_SHIFT = 14;
  localparam int ATT_SHIFT  = 29;

  // Saturation bounds of a 24-bit accumulator.
  localparam int ACC_MAX = 8388607;
  localparam int ACC_MIN = -8388608;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT,
    CFG_MIX_GAIN
  } cfg_reg_t;

  // Request codes.
  localparam logic REQ_ACCUMULATE = 1'b0;
  localparam logic REQ_CLEAR      = 1'b1;

  // Bed slot positions.
  localparam logic [SLOT_W-1:0] SLOT_L  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_R  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_C  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LS = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_RS = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic load;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic acc;
    logic wr;
    logic emit_zero;
    logic clr_init;
    logic clr_step;
  } sba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_clear;
    logic frame_ok;
    logic avg;
    logic div_last;
    logic slot_last;
    logic clr_last;
  } sba_status_t;

endpackage

/* rtl/surround_bed_accumulator.sv */
// Top level of the surround bed accumulator: controller plus datapath.
//
// Each accepted beat (start high while busy is low) is one request. An
// accumulate request gains the frame's samples, maps them onto the five bed
// slots and adds them with saturation into the addressed frame row; one
// result beat follows on out_strobe with the updated row. The slots pass one
// after another through the shared multipliers, each in a gain step, a -3 dB
// step and an accumulate step; the row is then written back and the result
// is registered from that write. Layouts of three, five or seven channels
// add a restoring divide by the channel count for each of the left and right
// slots. A frame index at or beyond FRAME_DEPTH reports zeros. A clear
// request reports zeros and then sweeps all FRAME_DEPTH rows of the memory
// one row per cycle; the same sweep runs after reset, with busy high. Busy
// stays high until a request is done. Results are strobed for one cycle and
// cannot be held off. Configuration writes take effect at once and belong in
// idle time.
module surround_bed_accumulator import sba_pkg::*; #(
  parameter int FRAME_DEPTH = DEFAULT_FRAME_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [FRAME_W-1:0]         in_frame_index,
  input  logic signed [SAMPLE_W-1:0] in_sample_0,
  input  logic signed [SAMPLE_W-1:0] in_sample_1,
  input  logic signed [SAMPLE_W-1:0] in_sample_2,
  input  logic signed [SAMPLE_W-1:0] in_sample_3,
  input  logic signed [SAMPLE_W-1:0] in_sample_4,
  input  logic signed [SAMPLE_W-1:0] in_sample_5,
  input  logic signed [SAMPLE_W-1:0] in_sample_6,
  input  logic signed [SAMPLE_W-1:0] in_sample_7,
  output logic                       out_strobe,
  output logic [FRAME_W-1:0]         out_frame,
  output logic signed [ACC_W-1:0]    out_bed_left,
  output logic signed [ACC_W-1:0]    out_bed_right,
  output logic signed [ACC_W-1:0]    out_bed_centre,
  output logic signed [ACC_W-1:0]    out_bed_left_surround,
  output logic signed [ACC_W-1:0]    out_bed_right_surround
);

  sba_cmd_t                   cmd;
  sba_status_t                st;
  logic signed [SAMPLE_W-1:0] samples [MAX_CHANNELS];
  logic signed [ACC_W-1:0]    bed [SLOTS];

  // Gather the sample ports in channel order.
  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  sba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  sba_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_frame_index (in_frame_index),
    .in_sample      (samples),
    .cmd            (cmd),
    .st             (st),
    .out_strobe     (out_strobe),
    .out_frame      (out_frame),
    .out_bed        (bed)
  );

  // Spread the bed row onto the result ports.
  assign out_bed_left           = bed[SLOT_L];
  assign out_bed_right          = bed[SLOT_R];
  assign out_bed_centre         = bed[SLOT_C];
  assign out_bed_left_surround  = bed[SLOT_LS];
  assign out_bed_right_surround = bed[SLOT_RS];

endmodule

/* rtl/sba_ctrl.sv */
// Controller state machine that sequences accumulate, clear and sweep work.
module sba_ctrl import sba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  sba_status_t st,
  output sba_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL1,
    ST_MUL2,
    ST_DIVI,
    ST_DIV,
    ST_ACC,
    ST_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and commands for the current state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.req_clear) begin
          cmd.emit_zero = 1'b1;
          cmd.clr_init  = 1'b1;
          state_nxt     = ST_CLR;
        end else if (!st.frame_ok) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = st.avg ? ST_DIVI : ST_ACC;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.slot_last ? ST_WR : ST_MUL1;
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered busy flag; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/sba_datapath.sv */
// Datapath: configuration registers, bed memory, shared multipliers, divider and saturating adder.
module sba_datapath import sba_pkg::*; #(
  parameter int FRAME_DEPTH = DEFAULT_FRAME_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_req_type,
  input  logic [FRAME_W-1:0]         in_frame_index,
  input  logic signed [SAMPLE_W-1:0] in_sample [MAX_CHANNELS],
  input  sba_cmd_t                   cmd,
  output sba_status_t                st,
  output logic                       out_strobe,
  output logic [FRAME_W-1:0]         out_frame,
  output logic signed [ACC_W-1:0]    out_bed [SLOTS]
);

  localparam int AW        = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int ROW_W     = SLOTS * ACC_W;
  localparam int SUM_W     = SAMPLE_W + 3;
  localparam int P1_W      = SUM_W + GAIN_W + 1;
  localparam int P2_W      = P1_W + GAIN_W + 1;
  localparam int DIVQ_W    = P2_W - ATT_SHIFT;
  localparam int DIVC_W    = $clog2(DIVQ_W);
  localparam int DIVR_W    = 3;
  localparam int CONTRIB_W = DIVQ_W + 1;
  localparam int ACCX_W    = ACC_W + 2;

  localparam logic signed [P1_W-1:0]   GAIN_BIAS = P1_W'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [P2_W-1:0]   ATT_BIAS  = P2_W'(1) <<< (ATT_SHIFT - 1);
  localparam logic signed [ACCX_W-1:0] SAT_HI    = ACCX_W'(ACC_MAX);
  localparam logic signed [ACCX_W-1:0] SAT_LO    = ACCX_W'(ACC_MIN);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_GAIN,
    MODE_ATT,
    MODE_AVG
  } mix_mode_t;

  // Configuration registers.
  logic [CC_W-1:0]   cc_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= CC_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: cc_r   <= cfg_wdata[CC_W-1:0];
        CFG_MIX_GAIN:      gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture at the accepted beat.
  logic                       req_clear_r;
  logic                       frame_ok_r;
  logic [FRAME_W-1:0]         frame_r;
  logic [AW-1:0]              addr_r;
  logic signed [SAMPLE_W-1:0] samp_r [MAX_CHANNELS];
  logic [31:0]                frame_ext;

  assign frame_ext = 32'(in_frame_index);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_clear_r <= (in_req_type == REQ_CLEAR);
      frame_ok_r  <= (frame_ext < 32'(FRAME_DEPTH));
      frame_r     <= in_frame_index;
      addr_r      <= frame_ext[AW-1:0];
      samp_r      <= in_sample;
    end
  end

  // Bed memory: one row of five accumulators per frame.
  logic [ROW_W-1:0] mem [FRAME_DEPTH];
  logic [ROW_W-1:0] rd_data_r;
  logic [ROW_W-1:0] row_packed;
  logic [ROW_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_waddr;
  logic             mem_we;
  logic [AW-1:0]    clr_cnt_r;

  assign mem_we    = cmd.wr | cmd.clr_step;
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
  assign mem_wdata = cmd.clr_step ? '0 : row_packed;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.latch) begin
      rd_data_r <= mem[frame_ext[AW-1:0]];
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_init) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Operand selection for the current slot by input layout.
  logic [SLOT_W-1:0]       slot_r;
  mix_mode_t               sel_mode;
  logic signed [SUM_W-1:0] sel_x;
  logic signed [SUM_W-1:0] sum_all;

  always_comb begin
    sum_all = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (CC_W'(k) < cc_r) begin
        sum_all = sum_all + SUM_W'(samp_r[k]);
      end
    end
  end

  always_comb begin
    sel_mode = MODE_NONE;
    sel_x    = '0;
    unique case (cc_r)
      4'd1: begin
        if (slot_r == SLOT_L || slot_r == SLOT_R) begin
          sel_mode = MODE_ATT;
          sel_x    = SUM_W'(samp_r[0]);
        end
      end
      4'd2: begin
        unique case (slot_r)
          SLOT_L: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[0]); end
          SLOT_R: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[1]); end
          default: ;
        endcase
      end
      4'd4: begin
        unique case (slot_r)
          SLOT_L:  begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[0]); end
          SLOT_R:  begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[1]); end
          SLOT_LS: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[2]); end
          SLOT_RS: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[3]); end
          default: ;
        endcase
      end
      4'd6: begin
        unique case (slot_r)
          SLOT_L:  begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[0]); end
          SLOT_R:  begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[1]); end
          SLOT_C:  begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[2]); end
          SLOT_LS: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[4]); end
          SLOT_RS: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[5]); end
          default: ;
        endcase
      end
      4'd8: begin
        unique case (slot_r)
          SLOT_L: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[0]); end
          SLOT_R: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[1]); end
          SLOT_C: begin sel_mode = MODE_GAIN; sel_x = SUM_W'(samp_r[2]); end
          SLOT_LS: begin
            sel_mode = MODE_ATT;
            sel_x    = SUM_W'(samp_r[4]) + SUM_W'(samp_r[6]);
          end
          SLOT_RS: begin
            sel_mode = MODE_ATT;
            sel_x    = SUM_W'(samp_r[5]) + SUM_W'(samp_r[7]);
          end
          default: ;
        endcase
      end
      4'd3, 4'd5, 4'd7: begin
        if (slot_r == SLOT_L || slot_r == SLOT_R) begin
          sel_mode = MODE_AVG;
          sel_x    = sum_all;
        end
      end
      default: ;
    endcase
  end

  // Shared multipliers: gain first, then the -3 dB factor in the next cycle.
  mix_mode_t              mode_r;
  logic signed [P1_W-1:0] p1_r;
  logic signed [P2_W-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1_r   <= P1_W'(sel_x) * P1_W'($signed({1'b0, gain_r}));
      mode_r <= sel_mode;
    end
    if (cmd.mul2) begin
      p2_r <= P2_W'(p1_r) * P2_W'($signed({1'b0, MINUS3DB_Q15}));
    end
  end

  // Averaging: add the channel count times 2^28, shift down by 29, then floor-divide by the channel count.
  logic signed [P2_W-1:0]   avg_bias;
  logic signed [P2_W-1:0]   avg_full;
  logic [DIVQ_W-1:0]        avg_t;
  logic [DIVQ_W-1:0]        avg_mag;
  logic [DIVR_W-1:0]        divisor;
  logic [DIVQ_W-1:0]        div_q_r;
  logic [DIVR_W-1:0]        div_rem_r;
  logic                     div_neg_r;
  logic [DIVC_W-1:0]        div_cnt_r;
  logic [DIVR_W:0]          rem_sh;
  logic                     rem_ge;

  assign divisor  = cc_r[DIVR_W-1:0];
  assign avg_bias = $signed(P2_W'(cc_r)) <<< (ATT_SHIFT - 1);
  assign avg_full = (p2_r + avg_bias) >>> ATT_SHIFT;
  assign avg_t    = avg_full[DIVQ_W-1:0];
  // For a negative value, floor(t/n) = -floor((~t + n) / n).
  assign avg_mag  = avg_t[DIVQ_W-1] ? (~avg_t + DIVQ_W'(cc_r)) : avg_t;
  assign rem_sh   = {div_rem_r, div_q_r[DIVQ_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_q_r   <= avg_mag;
      div_rem_r <= '0;
      div_neg_r <= avg_t[DIVQ_W-1];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[DIVQ_W-2:0], rem_ge};
      div_rem_r <= rem_ge ? DIVR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVR_W-1:0];
      div_cnt_r <= div_cnt_r + DIVC_W'(1);
    end
  end

  // Contribution of the current slot.
  logic signed [P1_W-1:0]      gain_full;
  logic signed [P2_W-1:0]      att_full;
  logic signed [DIVQ_W:0]      q_s;
  logic signed [DIVQ_W:0]      avg_c;
  logic signed [CONTRIB_W-1:0] contrib;

  assign gain_full = (p1_r + GAIN_BIAS) >>> GAIN_SHIFT;
  assign att_full  = (p2_r + ATT_BIAS) >>> ATT_SHIFT;
  assign q_s       = $signed({1'b0, div_q_r});
  assign avg_c     = div_neg_r ? -q_s : q_s;

  always_comb begin
    unique case (mode_r)
      MODE_GAIN: contrib = $signed(gain_full[CONTRIB_W-1:0]);
      MODE_ATT:  contrib = $signed(att_full[CONTRIB_W-1:0]);
      MODE_AVG:  contrib = CONTRIB_W'(avg_c);
      default:   contrib = '0;
    endcase
  end

  // Saturating add into the working row.
  logic signed [ACC_W-1:0]  row_r [SLOTS];
  logic signed [ACCX_W-1:0] acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;

  assign acc_sum = ACCX_W'(row_r[slot_r]) + ACCX_W'(contrib);

  always_comb begin
    priority if (acc_sum > SAT_HI) begin
      acc_sat = ACC_W'(SAT_HI);
    end else if (acc_sum < SAT_LO) begin
      acc_sat = ACC_W'(SAT_LO);
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      row_packed[i*ACC_W +: ACC_W] = row_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < SLOTS; i++) begin
        row_r[i] <= $signed(rd_data_r[i*ACC_W +: ACC_W]);
      end
    end else if (cmd.acc) begin
      row_r[slot_r] <= acc_sat;
    end
  end

  // Slot counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= '0;
    end else if (cmd.acc) begin
      slot_r <= slot_r + SLOT_W'(1);
    end
  end

  // Result register: one beat per request.
  logic                    out_strobe_r;
  logic [FRAME_W-1:0]      out_frame_r;
  logic signed [ACC_W-1:0] out_bed_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_zero | cmd.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      out_frame_r <= frame_r;
      for (int i = 0; i < SLOTS; i++) begin
        out_bed_r[i] <= '0;
      end
    end else if (cmd.wr) begin
      out_frame_r <= frame_r;
      out_bed_r   <= row_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_frame  = out_frame_r;
  assign out_bed    = out_bed_r;

  // Status to the controller.
  assign st.req_clear = req_clear_r;
  assign st.frame_ok  = frame_ok_r;
  assign st.avg       = (mode_r == MODE_AVG);
  assign st.div_last  = (div_cnt_r == DIVC_W'(DIVQ_W - 1));
  assign st.slot_last = (slot_r == SLOT_W'(SLOTS - 1));
  assign st.clr_last  = (clr_cnt_r == AW'(FRAME_DEPTH - 1));

endmodule

/* rtl/sba_checker.sv */
// Port-level assertions for the surround bed accumulator, bound to the top level.
module sba_checker import sba_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_req_type,
  input logic [FRAME_W-1:0]         in_frame_index,
  input logic                       out_strobe,
  input logic [FRAME_W-1:0]         out_frame,
  input logic signed [ACC_W-1:0]    out_bed_left,
  input logic signed [ACC_W-1:0]    out_bed_right,
  input logic signed [ACC_W-1:0]    out_bed_centre,
  input logic signed [ACC_W-1:0]    out_bed_left_surround,
  input logic signed [ACC_W-1:0]    out_bed_right_surround
);

  // An accepted beat makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  // Result beats never come in adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // The clearing sweep after reset keeps the block busy.
  a_busy_out_of_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> busy)
    else $error("block idle right after reset");

  // A clear request reports its frame with an all-zero bed on the result strobe.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_CLEAR)) |-> ##2
      (out_strobe && (out_frame == $past(in_frame_index, 2)) &&
       (out_bed_left == '0) && (out_bed_right == '0) && (out_bed_centre == '0) &&
       (out_bed_left_surround == '0) && (out_bed_right_surround == '0)))
    else $error("clear request result wrong");

endmodule

bind surround_bed_accumulator sba_checker u_sba_checker (.*);
